[hdl/eos_pkg.sv]
// Shared constants, types and helpers of the elevator order scheduler.
`default_nettype none
package eos_pkg;

  localparam int FLOORS  = 4;
  localparam int KINDS   = 3;
  localparam int QDEPTH  = FLOORS * KINDS;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int FLOOR_W = 2;
  localparam int KIND_W  = 2;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_POLL  = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_UP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAB  = 2'd2;

  localparam logic signed [1:0] DIR_DOWN = -2'sd1;
  localparam logic signed [1:0] DIR_STOP = 2'sd0;
  localparam logic signed [1:0] DIR_UP   = 2'sd1;

  localparam logic signed [2:0] NO_FLOOR = -3'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INSERT,
    ST_DROP,
    ST_COMPACT,
    ST_CHOOSE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                vld;
    logic [KIND_W-1:0]   kind;
    logic [FLOOR_W-1:0]  flr;
  } order_t;

  typedef struct packed {
    logic                clear;
    logic                drop;
    logic                compact;
    logic                append;
    logic [KIND_W-1:0]   probe_kind;
    logic [FLOOR_W-1:0]  probe_flr;
    logic signed [2:0]   cur;
    logic signed [1:0]   dir;
  } cmd_t;

  function automatic logic at_floor(logic [FLOOR_W-1:0] flr, logic signed [2:0] cur);
    return !cur[2] && (cur[FLOOR_W-1:0] == flr);
  endfunction

endpackage
`default_nettype wire

[hdl/eos_cell.sv]
// One queue slot: holds an order, appends, drops and shifts toward the head.
`default_nettype none
module eos_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  eos_pkg::cmd_t cmd,
  input  logic          prev_vld,
  input  logic          hole_in,
  input  eos_pkg::order_t next_ord,
  output eos_pkg::order_t ord,
  output logic          hole_out,
  output logic          dup,
  output logic          stop_hit
);
  import eos_pkg::*;

  logic               vld_r, vld_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [FLOOR_W-1:0] flr_r, flr_nxt;
  logic               hit_cur;
  logic               hole_here;

  assign hit_cur   = vld_r && at_floor(flr_r, cmd.cur);
  assign hole_here = hole_in || !vld_r;
  assign hole_out  = hole_here;
  assign ord       = '{vld: vld_r, kind: kind_r, flr: flr_r};
  assign dup       = vld_r && (kind_r == cmd.probe_kind) && (flr_r == cmd.probe_flr);
  assign stop_hit  = hit_cur && ((kind_r == KIND_CAB) ||
                                 (kind_r == KIND_DOWN && cmd.dir == DIR_DOWN) ||
                                 (kind_r == KIND_UP && cmd.dir == DIR_UP));

  always_comb begin
    vld_nxt  = vld_r;
    kind_nxt = kind_r;
    flr_nxt  = flr_r;
    priority if (cmd.clear) begin
      vld_nxt = 1'b0;
    end else if (cmd.drop) begin
      if (hit_cur) vld_nxt = 1'b0;
    end else if (cmd.compact) begin
      if (hole_here) begin
        vld_nxt  = next_ord.vld;
        kind_nxt = next_ord.kind;
        flr_nxt  = next_ord.flr;
      end
    end else if (cmd.append) begin
      if (!vld_r && prev_vld) begin
        vld_nxt  = 1'b1;
        kind_nxt = cmd.probe_kind;
        flr_nxt  = cmd.probe_flr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    kind_r <= kind_nxt;
    flr_r  <= flr_nxt;
  end

endmodule
`default_nettype wire

[hdl/eos_chain.sv]
// Row of queue cells with neighbor links and the match reductions.
`default_nettype none
module eos_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eos_pkg::cmd_t                 cmd,
  output eos_pkg::order_t               head,
  output logic                          dup_any,
  output logic                          stop_any,
  output logic [eos_pkg::QDEPTH-1:0]    vld_vec
);
  import eos_pkg::*;

  order_t            ords  [QDEPTH];
  logic [QDEPTH-1:0] holes;
  logic [QDEPTH-1:0] dup_vec;
  logic [QDEPTH-1:0] stop_vec;

  for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
    logic   prev_vld;
    logic   hole_in;
    order_t next_ord;

    if (i == 0) begin : g_first
      assign prev_vld = 1'b1;
      assign hole_in  = 1'b0;
    end else begin : g_mid
      assign prev_vld = ords[i-1].vld;
      assign hole_in  = holes[i-1];
    end

    if (i == QDEPTH - 1) begin : g_last
      assign next_ord = '0;
    end else begin : g_link
      assign next_ord = ords[i+1];
    end

    eos_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_vld (prev_vld),
      .hole_in  (hole_in),
      .next_ord (next_ord),
      .ord      (ords[i]),
      .hole_out (holes[i]),
      .dup      (dup_vec[i]),
      .stop_hit (stop_vec[i])
    );

    assign vld_vec[i] = ords[i].vld;
  end

  assign head     = ords[0];
  assign dup_any  = |dup_vec;
  assign stop_any = |stop_vec;

endmodule
`default_nettype wire

[hdl/elevator_order_scheduler.sv]
// Top level of the elevator order scheduler: transaction sequencer and result register.
// A clear, stop or unused code passes through a start state and a finish state. A poll
// also walks the twelve button bits, one per cycle, through the queue cell row, and
// then picks the target. If the door was open it first drops the orders for the current
// floor and shifts the row to close the gaps before the target is picked. The finish
// state repeats while the output register holds a stalled result. in_stall is
// high while a transaction is in work; the next transaction can be taken from the cycle
// after the result is loaded, while that result still waits in the output register.
`default_nettype none
module elevator_order_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [11:0]        in_button_bits,
  input  logic signed [2:0]  in_current_floor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [1:0]  out_motor_dir,
  output logic               out_stop_request,
  output logic               out_door_open,
  output logic signed [2:0]  out_target_floor
);
  import eos_pkg::*;

  state_t              state_r, state_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [QDEPTH-1:0]   buttons_r, buttons_nxt;
  logic signed [2:0]   cur_r, cur_nxt;
  logic [QIDX_W-1:0]   cnt_r, cnt_nxt;
  logic [KIND_W-1:0]   kind_cnt_r, kind_cnt_nxt;
  logic [FLOOR_W-1:0]  flr_cnt_r, flr_cnt_nxt;
  logic signed [1:0]   dir_r, dir_nxt;
  logic signed [2:0]   goal_r, goal_nxt;
  logic                door_r, door_nxt;
  logic signed [1:0]   motor_r, motor_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [1:0]   out_motor_r, out_motor_nxt;
  logic                out_stop_r, out_stop_nxt;
  logic                out_door_r, out_door_nxt;
  logic signed [2:0]   out_target_r, out_target_nxt;

  cmd_t                cmd;
  order_t              head;
  logic                dup_any;
  logic                stop_any;
  logic [QDEPTH-1:0]   vld_vec;
  logic signed [2:0]   head_flr;

  eos_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .head     (head),
    .dup_any  (dup_any),
    .stop_any (stop_any),
    .vld_vec  (vld_vec)
  );

  assign head_flr = $signed({1'b0, head.flr});

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    buttons_nxt    = buttons_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    kind_cnt_nxt   = kind_cnt_r;
    flr_cnt_nxt    = flr_cnt_r;
    dir_nxt        = dir_r;
    goal_nxt       = goal_r;
    door_nxt       = door_r;
    motor_nxt      = motor_r;
    out_motor_nxt  = out_motor_r;
    out_stop_nxt   = out_stop_r;
    out_door_nxt   = out_door_r;
    out_target_nxt = out_target_r;
    out_valid_nxt  = out_valid_r && out_stall;

    cmd            = '0;
    cmd.cur        = cur_r;
    cmd.dir        = dir_r;
    cmd.probe_kind = kind_cnt_r;
    cmd.probe_flr  = flr_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          buttons_nxt = in_button_bits;
          cur_nxt     = in_current_floor;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        motor_nxt = DIR_STOP;
        state_nxt = ST_FINISH;
        unique case (func_r)
          FUNC_CLEAR: begin
            cmd.clear = 1'b1;
            dir_nxt   = DIR_STOP;
          end
          FUNC_POLL: begin
            cnt_nxt      = '0;
            kind_cnt_nxt = KIND_UP;
            flr_cnt_nxt  = '0;
            state_nxt    = ST_INSERT;
          end
          FUNC_STOP: begin
            if (cur_r == goal_r) dir_nxt = DIR_STOP;
            door_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_INSERT: begin
        cmd.append = buttons_r[cnt_r] && !at_floor(flr_cnt_r, cur_r) && !dup_any;
        cnt_nxt    = cnt_r + 1'b1;
        if (kind_cnt_r == KIND_CAB) begin
          kind_cnt_nxt = KIND_UP;
          flr_cnt_nxt  = flr_cnt_r + 1'b1;
        end else begin
          kind_cnt_nxt = kind_cnt_r + 1'b1;
        end
        if (cnt_r == QIDX_W'(QDEPTH - 1)) begin
          if (door_r) begin
            door_nxt  = 1'b0;
            state_nxt = ST_DROP;
          end else begin
            state_nxt = ST_CHOOSE;
          end
        end
      end
      ST_DROP: begin
        cmd.drop  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_COMPACT;
      end
      ST_COMPACT: begin
        cmd.compact = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == QIDX_W'(QDEPTH - 1)) state_nxt = ST_CHOOSE;
      end
      ST_CHOOSE: begin
        motor_nxt = dir_r;
        if (dir_r == DIR_STOP && head.vld) begin
          goal_nxt = head_flr;
          priority if (head_flr > cur_r) begin
            dir_nxt = DIR_UP;
          end else if (head_flr < cur_r) begin
            dir_nxt = DIR_DOWN;
          end else begin
            dir_nxt = DIR_STOP;
          end
          motor_nxt = dir_nxt;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_motor_nxt  = motor_r;
          out_stop_nxt   = (goal_r == cur_r) || stop_any;
          out_door_nxt   = door_r;
          out_target_nxt = goal_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dir_r       <= DIR_STOP;
      goal_r      <= NO_FLOOR;
      door_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      goal_r      <= goal_nxt;
      door_r      <= door_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    buttons_r    <= buttons_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    kind_cnt_r   <= kind_cnt_nxt;
    flr_cnt_r    <= flr_cnt_nxt;
    motor_r      <= motor_nxt;
    out_motor_r  <= out_motor_nxt;
    out_stop_r   <= out_stop_nxt;
    out_door_r   <= out_door_nxt;
    out_target_r <= out_target_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_motor_dir    = out_motor_r;
  assign out_stop_request = out_stop_r;
  assign out_door_open    = out_door_r;
  assign out_target_floor = out_target_r;

  // queue is a packed prefix whenever no transaction is in work
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((vld_vec & QDEPTH'(vld_vec + 1'b1)) == '0))
    else $error("order queue not packed at idle");

  a_goal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CHOOSE) |=> $stable(goal_r))
    else $error("target changed outside target choice");

  a_door_served: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHOOSE) |-> !door_r)
    else $error("door flag still set at target choice");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished transaction did not reach the output register");

endmodule
`default_nettype wire
